// ----- rtl/she_pkg.sv -----
package she_pkg;

  // Message and size limits
  localparam int unsigned MaxMessageBytes = 1024;
  localparam logic [15:0] HeaderBytes     = 16'd3;
  localparam logic [15:0] SatMax          = 16'hFFFF;

  // Escape: 12-bit prefix, then the 8 raw bits
  localparam logic [11:0] EscapeCode = 12'hFE0;
  localparam logic [4:0]  EscapedLen = 5'd20;

  // Code ROM layout: 10 codes of 5 bits, 24 of 6, 24 of 7, 30 of 8
  localparam int unsigned RomSize  = 88;
  localparam logic [7:0]  Len6Idx  = 8'd10;
  localparam logic [7:0]  Len7Idx  = 8'd34;
  localparam logic [7:0]  Len8Idx  = 8'd58;
  localparam logic [7:0]  Len6Base = 8'h14;
  localparam logic [7:0]  Len7Base = 8'h58;
  localparam logic [7:0]  Len8Base = 8'hE0;

  // Symbols in code order; entry 0 sits in the top byte
  localparam logic [RomSize*8-1:0] CodeRom =
    {" etaoinshr", "dlcumwfgypbvkjxqzEATOISH", "RNDLCMUWFGYPBVKJXQZ01234",
     "56789.,!?;:'\"_-@#/()+=%&*<>[]{"};

  // Encoder state carried from item to item
  typedef struct packed {
    logic [6:0]  bits;
    logic [2:0]  cnt;
    logic [15:0] bytes;
    logic [15:0] syms;
    logic        ovf;
  } enc_state_t;

  // Results of one item, ready for the output sequencer
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nres;
    logic        marker;
    logic        last;
    logic        ovf;
    logic [15:0] total;
    logic        pass;
  } bundle_t;

  // Returns {length, code bit-reversed so the earliest bit is bit 0}
  function automatic logic [24:0] code_lookup(input logic [7:0] sym);
    logic        found;
    logic [7:0]  idx;
    logic [19:0] code;
    logic [4:0]  len;
    logic [19:0] rev;
    found = 1'b0;
    idx   = 8'd0;
    for (int i = 0; i < RomSize; i++) begin
      if (!found && CodeRom[(RomSize-1-i)*8 +: 8] == sym) begin
        found = 1'b1;
        idx   = 8'(i);
      end
    end
    if (!found) begin
      code = {EscapeCode, sym};
      len  = EscapedLen;
    end else if (idx < Len6Idx) begin
      code = {12'd0, idx};
      len  = 5'd5;
    end else if (idx < Len7Idx) begin
      code = {12'd0, 8'(Len6Base + (idx - Len6Idx))};
      len  = 5'd6;
    end else if (idx < Len8Idx) begin
      code = {12'd0, 8'(Len7Base + (idx - Len7Idx))};
      len  = 5'd7;
    end else begin
      code = {12'd0, 8'(Len8Base + (idx - Len8Idx))};
      len  = 5'd8;
    end
    for (int b = 0; b < 20; b++) begin
      rev[b] = (5'(b) < len) ? code[5'(len - 5'd1 - 5'(b))] : 1'b0;
    end
    return {len, rev};
  endfunction

endpackage

// ----- rtl/she_pack.sv -----
module she_pack (
  input  she_pkg::enc_state_t st_i,
  input  logic [7:0]          sym_i,
  input  logic                last_i,
  input  logic [15:0]         max_bytes_i,
  output she_pkg::enc_state_t st_o,
  output she_pkg::bundle_t    bnd_o
);
  import she_pkg::*;

  logic        drop;
  logic [24:0] lk;
  logic [4:0]  add_len;
  logic [31:0] win;
  logic [31:0] rest;
  logic [4:0]  nbits;
  logic [1:0]  nb;
  logic [2:0]  rem_bits;
  logic        flush;
  logic        pend;
  logic [2:0]  nf;
  logic [3:0]  ok;
  logic [2:0]  emit;
  logic        part_ovf;
  logic [16:0] tot_sum;
  logic [16:0] cnt_sum;
  logic [15:0] total;
  logic [15:0] syms_next;
  logic        ovf;

  // Code lookup; a dropped symbol adds no bits
  assign drop    = st_i.syms >= 16'(MaxMessageBytes);
  assign lk      = code_lookup(sym_i);
  assign add_len = drop ? 5'd0 : lk[24:20];

  // Append the new code above the pending bits
  assign win      = {25'd0, st_i.bits} | (drop ? 32'd0 : ({12'd0, lk[19:0]} << st_i.cnt));
  assign nbits    = 5'(st_i.cnt) + add_len;
  assign nb       = nbits[4:3];
  assign rem_bits = nbits[2:0];
  assign rest     = win >> {nb, 3'b000};
  assign flush    = last_i && (rem_bits != 3'd0);
  assign pend     = !last_i && (rem_bits != 3'd0);
  assign nf       = {1'b0, nb} + {2'b00, flush};

  // Byte index k is emitted only while below the limit
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ok[k] = ({1'b0, st_i.bytes} + 17'(k)) < {1'b0, max_bytes_i};
    end
  end

  // Emitted bytes form a prefix of the produced ones
  always_comb begin
    emit = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (ok[k] && (3'(k) < nf)) emit = emit + 3'd1;
    end
  end

  assign part_ovf = (rem_bits != 3'd0) && !ok[nb];

  // Size bookkeeping, saturating
  assign tot_sum   = {1'b0, st_i.bytes} + 17'(nf) + 17'(pend);
  assign total     = tot_sum[16] ? SatMax : tot_sum[15:0];
  assign cnt_sum   = {1'b0, st_i.bytes} + 17'(nb);
  assign syms_next = st_i.syms + 16'(!drop);
  assign ovf       = st_i.ovf | drop | (nf > emit) | part_ovf;

  // Result bundle; an empty message end gives one marker
  always_comb begin
    bnd_o.marker = (emit == 3'd0);
    bnd_o.data   = bnd_o.marker ? 32'd0 : win;
    bnd_o.nres   = (bnd_o.marker && last_i) ? 3'd1 : emit;
    bnd_o.last   = last_i;
    bnd_o.ovf    = ovf;
    bnd_o.total  = total;
    bnd_o.pass   = last_i && ({1'b0, total} >= ({1'b0, syms_next} + 17'd1));
  end

  // Next state; message end returns to reset values
  always_comb begin
    if (last_i) begin
      st_o.bits  = 7'd0;
      st_o.cnt   = 3'd0;
      st_o.bytes = HeaderBytes;
      st_o.syms  = 16'd0;
      st_o.ovf   = 1'b0;
    end else begin
      st_o.bits  = rest[6:0];
      st_o.cnt   = rem_bits;
      st_o.bytes = cnt_sum[16] ? SatMax : cnt_sum[15:0];
      st_o.syms  = syms_next;
      st_o.ovf   = ovf;
    end
  end

endmodule

// ----- rtl/static_huffman_escape_encoder.sv -----
// Static Huffman encoder with escape.
// Accepted items wait in the input register; their results in the output register.
// Throughput: one item per cycle while items give at most one result and the output is
// not stalled; an item of n results (up to four) holds the single output register.
// Reset (rst_ni low, async): pipeline empty, bit packer and counters cleared,
// byte count at three header bytes, output limit at 65535.
module static_huffman_escape_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,   // max_output_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] symbol
  input  logic        s_axis_tlast,    // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [8] overflow, [24:9] total_bytes, [25] passthrough_better
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,    // [0] byte_valid, [1] run_end
  output logic        m_axis_tlast     // message_end
);
  import she_pkg::*;

  logic        in_valid_q;
  logic [7:0]  sym_q;
  logic        last_q;
  logic [15:0] max_q;
  enc_state_t  st_q, st_d;
  bundle_t     bnd;
  logic [2:0]  rem_q;
  logic [31:0] data_q;
  logic        marker_q;
  logic        blast_q;
  logic        ovf_q;
  logic [15:0] total_q;
  logic        pass_q;
  logic        bundle_free;
  logic        proc;
  logic        out_fire;

  // Handshake control
  assign m_axis_tvalid = (rem_q != 3'd0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign bundle_free   = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready);
  assign proc          = in_valid_q && bundle_free;
  assign s_axis_tready = !in_valid_q || proc;

  she_pack u_pack (
    .st_i        (st_q),
    .sym_i       (sym_q),
    .last_i      (last_q),
    .max_bytes_i (max_q),
    .st_o        (st_d),
    .bnd_o       (bnd)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      max_q      <= SatMax;
      st_q       <= '{bits: 7'd0, cnt: 3'd0, bytes: HeaderBytes, syms: 16'd0, ovf: 1'b0};
      rem_q      <= 3'd0;
    end else begin
      if (cfg_wr_en_i) max_q <= cfg_wr_data_i;
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (proc) begin
        st_q  <= st_d;
        rem_q <= bnd.nres;
      end else if (out_fire) begin
        rem_q <= rem_q - 3'd1;
      end
    end
  end

  // Input register and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sym_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (proc) begin
      data_q   <= bnd.data;
      marker_q <= bnd.marker;
      blast_q  <= bnd.last;
      ovf_q    <= bnd.ovf;
      total_q  <= bnd.total;
      pass_q   <= bnd.pass;
    end else if (out_fire) begin
      data_q <= data_q >> 8;
    end
  end

  // Output fields
  assign m_axis_tdata = {6'd0, pass_q, total_q, ovf_q, data_q[7:0]};
  assign m_axis_tuser = {(rem_q == 3'd1), !marker_q};
  assign m_axis_tlast = (rem_q == 3'd1) && blast_q;

`ifndef ASSERT_OFF
  a_marker_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tuser[1] && m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
    else $error("marker item is not a lone zero end-of-message item");

  a_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
    else $error("message end without run end");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_q) |=>
      (st_q.syms == 16'd0 && st_q.cnt == 3'd0 && st_q.bytes == HeaderBytes && !st_q.ovf))
    else $error("encoder state not cleared after message end");

  a_sym_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.syms <= 16'(MaxMessageBytes))
    else $error("symbol count beyond message limit");
`endif

endmodule
